// ===== rtl/core/tds_pkg.sv =====
`timescale 1ns / 1ps

package tds_pkg;

   // Field and accumulator widths
   localparam int unsigned SampleWidth = 7;
   localparam int unsigned AlleleWidth = 64;
   localparam int unsigned DiffWidth   = 27;
   localparam int unsigned SiteWidth   = 17;
   localparam int unsigned DWidth      = 32;
   localparam int unsigned ThetaWidth  = 40;
   localparam int unsigned WordWidth   = 64;
   localparam int unsigned ShWidth     = 7;
   localparam int unsigned CntWidth    = 8;

   // Fixed-point layout: constants in Q40, variance in Q32
   localparam int unsigned FracBits = 40;
   localparam int unsigned VarShift = 8;
   localparam logic [WordWidth-1:0] Residue = 64'd256;
   localparam logic [ShWidth-1:0] ShPi   = 7'd40;
   localparam logic [ShWidth-1:0] ShThw  = 7'd80;
   localparam logic [ShWidth-1:0] ShQuot = 7'd0;

   // Register map
   localparam logic RegNumSamples = 1'b0;
   localparam logic [SampleWidth-1:0] NumSamplesReset = 7'd64;

   // One entry per sample count, 0 .. 64
   localparam int unsigned TabDepth = 65;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_GROUP,
      ST_SUM,
      ST_ADD,
      ST_LOOKUP,
      ST_VAR1_GO,
      ST_VAR1_WAIT,
      ST_VAR2_GO,
      ST_VAR2_WAIT,
      ST_PI_GO,
      ST_PI_WAIT,
      ST_THW_GO,
      ST_THW_WAIT,
      ST_ROOT_GO,
      ST_ROOT_WAIT,
      ST_QUOT_GO,
      ST_QUOT_WAIT,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_VAR1,
      OP_VAR2,
      OP_PI,
      OP_THW,
      OP_ROOT,
      OP_QUOT
   } op_type;

   typedef struct packed {
      logic   load_site;
      logic   count;
      logic   sum;
      logic   add;
      logic   lookup;
      logic   start;
      op_type op;
      logic   load_rsp;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic mul_done;
      logic div_done;
      logic root_done;
      logic var_zero;
   } stat_type;

   typedef struct packed {
      logic [WordWidth-1:0] hs1;
      logic [WordWidth-1:0] ee1;
      logic [WordWidth-1:0] ee2;
   } tab_entry_type;

   typedef tab_entry_type [TabDepth-1:0] tab_type;

   // round(x * 2^sh / d), ties up, saturating; bad divisor gives all ones
   function automatic logic [WordWidth-1:0] div_sh_c(logic [WordWidth-1:0] x, int sh,
                                                     logic [WordWidth-1:0] d);
      logic [WordWidth-1:0] q;
      logic [WordWidth-1:0] r;
      logic ovf;
      logic b;
      int i;
      q   = '0;
      r   = '0;
      ovf = 1'b0;
      if (d == '0 || d[63:62] != 2'b00) begin
         return '1;
      end
      for (i = 63 + sh; i >= 0; i--) begin
         b = (i >= sh) ? x[i - sh] : 1'b0;
         if (q[63]) begin
            ovf = 1'b1;
         end
         q = {q[62:0], 1'b0};
         r = {r[62:0], b};
         if (r >= d) begin
            r    = r - d;
            q[0] = 1'b1;
         end
      end
      if (r >= d - r) begin
         if (q == '1) begin
            ovf = 1'b1;
         end else begin
            q = q + 64'd1;
         end
      end
      return ovf ? '1 : q;
   endfunction

   // round(a * b / 2^sh), ties up, saturating
   function automatic logic [WordWidth-1:0] mul_sh_c(logic [WordWidth-1:0] a,
                                                     logic [WordWidth-1:0] b, int sh);
      logic [128:0] p;
      p = {65'b0, a} * {65'b0, b};
      p = p + (129'd1 << (sh - 1));
      if ((p >> (64 + sh)) != '0) begin
         return '1;
      end
      return 64'(p >> sh);
   endfunction

   // Per sample count: harmonic sum a1 and variance weights e1, e2
   function automatic tab_type build_tab();
      tab_type t;
      logic [WordWidth-1:0] hs1, hs2, n64, bb1, bb2, inv, tt, sq;
      logic [WordWidth-1:0] cc1, cc2, cc1u, cc2u, ee1, ee2, den;
      int n;
      t   = '0;
      hs1 = '0;
      hs2 = '0;
      for (n = 2; n < TabDepth; n++) begin
         n64  = 64'(n);
         hs1  = hs1 + div_sh_c(64'd1, FracBits, n64 - 64'd1);
         hs2  = hs2 + div_sh_c(64'd1, FracBits, (n64 - 64'd1) * (n64 - 64'd1));
         bb1  = div_sh_c(n64 + 64'd1, FracBits, 64'd3 * (n64 - 64'd1));
         bb2  = div_sh_c(64'd2 * (n64 * n64 + n64 + 64'd3), FracBits,
                         64'd9 * n64 * (n64 - 64'd1));
         inv  = div_sh_c(64'd1, 2 * FracBits, hs1);
         tt   = div_sh_c((n64 + 64'd2) * inv, 0, n64);
         sq   = mul_sh_c(hs2, mul_sh_c(inv, inv, FracBits), FracBits);
         cc1  = bb1 - inv;
         cc2  = bb2 - tt + sq;
         cc1u = ($signed(cc1) < $signed(Residue)) ? '0 : cc1;
         cc2u = ($signed(cc2) < $signed(Residue)) ? '0 : cc2;
         ee1  = mul_sh_c(cc1u, inv, FracBits);
         den  = mul_sh_c(hs1, hs1, FracBits) + hs2;
         ee2  = div_sh_c(cc2u, FracBits, den);
         t[n] = '{hs1: hs1, ee1: ee1, ee2: ee2};
      end
      // counts below two behave as two
      t[0] = t[2];
      t[1] = t[2];
      return t;
   endfunction

   localparam tab_type ConstTab = build_tab();

endpackage

// ===== rtl/core/tds_divider.sv =====
`timescale 1ns / 1ps

module tds_divider
   import tds_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [WordWidth-1:0] x,
   input  logic [ShWidth-1:0]   sh,
   input  logic [WordWidth-1:0] d,
   output logic                 done,
   output logic [WordWidth-1:0] q
);

   logic [WordWidth-1:0] num_ff, den_ff, rem_ff, quo_ff;
   logic [CntWidth-1:0]  cnt_ff;
   logic                 busy_ff, rnd_ff, done_ff, ovf_ff, bad_ff;

   logic [WordWidth-1:0] rem_shift, rem_in, quo_in, half_in;
   logic                 rem_ge, ovf_in, round_up;

   // One quotient bit per cycle
   always_comb begin
      rem_shift = {rem_ff[62:0], num_ff[63]};
      rem_ge    = (rem_shift >= den_ff);
      rem_in    = rem_ge ? (rem_shift - den_ff) : rem_shift;
      quo_in    = {quo_ff[62:0], rem_ge};
      ovf_in    = ovf_ff | quo_ff[63];
      round_up  = (rem_ff >= (den_ff - rem_ff));
      half_in   = quo_ff + 64'd1;
   end

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rnd_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= rnd_ff;
         rnd_ff  <= busy_ff && (cnt_ff == 8'd1);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == 8'd1) begin
            busy_ff <= 1'b0;
         end
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= x;
         den_ff <= d;
         rem_ff <= '0;
         quo_ff <= '0;
         ovf_ff <= 1'b0;
         bad_ff <= (d == '0) || (d[63:62] != 2'b00);
         cnt_ff <= 8'd64 + 8'(sh);
      end else if (busy_ff) begin
         num_ff <= {num_ff[62:0], 1'b0};
         rem_ff <= rem_in;
         quo_ff <= quo_in;
         ovf_ff <= ovf_in;
         cnt_ff <= cnt_ff - 8'd1;
      end else if (rnd_ff) begin
         // round half up, saturate on overflow or bad divisor
         if (bad_ff || ovf_ff || (round_up && quo_ff == '1)) begin
            quo_ff <= '1;
         end else if (round_up) begin
            quo_ff <= half_in;
         end
      end
   end

   assign done = done_ff;
   assign q    = quo_ff;

endmodule

// ===== rtl/core/tds_ctrl.sv =====
`timescale 1ns / 1ps

module tds_ctrl
   import tds_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_valid,
   output logic     req_ready,
   output logic     rsp_valid,
   input  logic     rsp_ready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_GROUP;
         ST_GROUP:     state_in = ST_SUM;
         ST_SUM:       state_in = ST_ADD;
         ST_ADD:       state_in = stat.last ? ST_LOOKUP : ST_IDLE;
         ST_LOOKUP:    state_in = ST_VAR1_GO;
         ST_VAR1_GO:   state_in = ST_VAR1_WAIT;
         ST_VAR1_WAIT: if (stat.mul_done) state_in = ST_VAR2_GO;
         ST_VAR2_GO:   state_in = ST_VAR2_WAIT;
         ST_VAR2_WAIT: if (stat.mul_done) state_in = ST_PI_GO;
         ST_PI_GO:     state_in = ST_PI_WAIT;
         ST_PI_WAIT:   if (stat.div_done) state_in = ST_THW_GO;
         ST_THW_GO:    state_in = ST_THW_WAIT;
         ST_THW_WAIT: begin
            if (stat.div_done) state_in = stat.var_zero ? ST_FINISH : ST_ROOT_GO;
         end
         ST_ROOT_GO:   state_in = ST_ROOT_WAIT;
         ST_ROOT_WAIT: if (stat.root_done) state_in = ST_QUOT_GO;
         ST_QUOT_GO:   state_in = ST_QUOT_WAIT;
         ST_QUOT_WAIT: if (stat.div_done) state_in = ST_FINISH;
         ST_FINISH:    if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      cmd.op    = OP_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_site = req_valid;
         end
         ST_GROUP:     cmd.count = 1'b1;
         ST_SUM:       cmd.sum = 1'b1;
         ST_ADD:       cmd.add = 1'b1;
         ST_LOOKUP:    cmd.lookup = 1'b1;
         ST_VAR1_GO: begin
            cmd.start = 1'b1;
            cmd.op    = OP_VAR1;
         end
         ST_VAR1_WAIT: cmd.op = OP_VAR1;
         ST_VAR2_GO: begin
            cmd.start = 1'b1;
            cmd.op    = OP_VAR2;
         end
         ST_VAR2_WAIT: cmd.op = OP_VAR2;
         ST_PI_GO: begin
            cmd.start = 1'b1;
            cmd.op    = OP_PI;
         end
         ST_PI_WAIT:   cmd.op = OP_PI;
         ST_THW_GO: begin
            cmd.start = 1'b1;
            cmd.op    = OP_THW;
         end
         ST_THW_WAIT:  cmd.op = OP_THW;
         ST_ROOT_GO: begin
            cmd.start = 1'b1;
            cmd.op    = OP_ROOT;
         end
         ST_ROOT_WAIT: cmd.op = OP_ROOT;
         ST_QUOT_GO: begin
            cmd.start = 1'b1;
            cmd.op    = OP_QUOT;
         end
         ST_QUOT_WAIT: cmd.op = OP_QUOT;
         ST_FINISH:    cmd.load_rsp = !rsp_valid_ff || rsp_ready;
         default:      cmd = '0;
      endcase
   end

   // Hold the result valid until taken
   assign rsp_valid_in = cmd.load_rsp ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== rtl/core/tds_datapath.sv =====
`timescale 1ns / 1ps

module tds_datapath
   import tds_pkg::*;
#(
   parameter int unsigned MAX_SAMPLES = 64,
   parameter int unsigned MAX_SITES   = 65536
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cmd_type                  cmd,
   output stat_type                 stat,
   input  logic [SampleWidth-1:0]   num_samples,
   input  logic [AlleleWidth-1:0]   req_site_alleles,
   input  logic                     req_last_site,
   output logic signed [DWidth-1:0] rsp_d_stat,
   output logic [ThetaWidth-1:0]    rsp_theta_pi,
   output logic [ThetaWidth-1:0]    rsp_theta_watterson,
   output logic                     rsp_status
);

   localparam logic [SampleWidth-1:0] NMax = SampleWidth'(MAX_SAMPLES);
   localparam int unsigned SiteCapInt = (MAX_SITES < 131071) ? MAX_SITES : 131071;
   localparam logic [SiteWidth-1:0] SiteCap = SiteWidth'(SiteCapInt);

   logic [SampleWidth-1:0] n_eff;
   logic [AlleleWidth-1:0] mask;

   // Clamp the sample count and mask unused samples
   always_comb begin
      if (num_samples < 7'd2) begin
         n_eff = 7'd2;
      end else if (num_samples > NMax) begin
         n_eff = NMax;
      end else begin
         n_eff = num_samples;
      end
      for (int i = 0; i < AlleleWidth; i++) begin
         mask[i] = (7'(i) < n_eff);
      end
   end

   // ---------------- per-site accumulation ----------------
   logic [AlleleWidth-1:0] alleles_ff;
   logic                   last_ff;
   logic [7:0][3:0]        grp_ff, grp_in;
   logic [6:0]             k_ff, k_in;
   logic [DiffWidth-1:0]   diff_ff;
   logic [SiteWidth-1:0]   site_ff;
   logic [13:0]            pair_prod;
   logic [27:0]            diff_sum;

   always_comb begin
      for (int g = 0; g < 8; g++) begin
         grp_in[g] = '0;
         for (int b = 0; b < 8; b++) begin
            grp_in[g] = grp_in[g] + 4'(alleles_ff[8*g + b]);
         end
      end
      k_in = '0;
      for (int g = 0; g < 8; g++) begin
         k_in = k_in + 7'(grp_ff[g]);
      end
      pair_prod = 14'(k_ff) * 14'(n_eff - k_ff);
      diff_sum  = 28'(diff_ff) + 28'(pair_prod);
   end

   // Capture the site, count ones in two steps
   always_ff @(posedge clock) begin
      if (cmd.load_site) begin
         alleles_ff <= req_site_alleles & mask;
         last_ff    <= req_last_site;
      end
      if (cmd.count) grp_ff <= grp_in;
      if (cmd.sum) k_ff <= k_in;
   end

   // Accumulate differences and sites, saturating; clear on result
   always_ff @(posedge clock) begin
      if (reset) begin
         diff_ff <= '0;
         site_ff <= '0;
      end else if (cmd.load_rsp) begin
         diff_ff <= '0;
         site_ff <= '0;
      end else if (cmd.add) begin
         diff_ff <= diff_sum[27] ? '1 : diff_sum[DiffWidth-1:0];
         if (site_ff < SiteCap) site_ff <= site_ff + 17'd1;
      end
   end

   // ---------------- constants for this sample count ----------------
   logic [WordWidth-1:0] hs1_ff, ee1_ff, ee2_ff;
   logic [33:0]          ss_ff;
   logic [11:0]          pidiv_ff;
   logic [13:0]          n_pairs;

   assign n_pairs = 14'(n_eff) * 14'(n_eff - 7'd1);

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         hs1_ff   <= ConstTab[n_eff].hs1;
         ee1_ff   <= ConstTab[n_eff].ee1;
         ee2_ff   <= ConstTab[n_eff].ee2;
         ss_ff    <= 34'(site_ff) * 34'(site_ff - 17'd1);
         pidiv_ff <= n_pairs[12:1];
      end
   end

   // ---------------- 64x64 multiplier, one 32x32 product per cycle ----------------
   logic [WordWidth-1:0] mul_a_ff, mul_b_ff, mul_pp_ff, mul_res_ff;
   logic [127:0]         mul_acc_ff, mul_add;
   logic [1:0]           mul_sel_ff;
   logic [2:0]           mul_step_ff;
   logic                 mul_busy_ff, mul_rnd_ff, mul_done_ff, mul_start;
   logic [31:0]          mul_ah, mul_bh;
   logic [128:0]         mul_rnd_sum;

   assign mul_start = cmd.start && (cmd.op == OP_VAR1 || cmd.op == OP_VAR2);

   always_comb begin
      mul_ah = mul_step_ff[1] ? mul_a_ff[63:32] : mul_a_ff[31:0];
      mul_bh = mul_step_ff[0] ? mul_b_ff[63:32] : mul_b_ff[31:0];
      case (mul_sel_ff) inside
         2'd0:       mul_add = {64'b0, mul_pp_ff};
         2'd1, 2'd2: mul_add = {32'b0, mul_pp_ff, 32'b0};
         default:    mul_add = {mul_pp_ff, 64'b0};
      endcase
      mul_rnd_sum = {1'b0, mul_acc_ff} + (129'd1 << (VarShift - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_busy_ff <= 1'b0;
         mul_rnd_ff  <= 1'b0;
         mul_done_ff <= 1'b0;
      end else begin
         mul_done_ff <= mul_rnd_ff;
         mul_rnd_ff  <= mul_busy_ff && (mul_step_ff == 3'd4);
         if (mul_start) begin
            mul_busy_ff <= 1'b1;
         end else if (mul_busy_ff && mul_step_ff == 3'd4) begin
            mul_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mul_start) begin
         mul_a_ff    <= (cmd.op == OP_VAR1) ? ee1_ff : ee2_ff;
         mul_b_ff    <= (cmd.op == OP_VAR1) ? 64'(site_ff) : 64'(ss_ff);
         mul_acc_ff  <= '0;
         mul_step_ff <= '0;
      end else if (mul_busy_ff) begin
         // register each partial product, add it in the next cycle
         if (mul_step_ff != 3'd4) begin
            mul_pp_ff  <= 64'(mul_ah) * 64'(mul_bh);
            mul_sel_ff <= mul_step_ff[1:0];
         end
         if (mul_step_ff != 3'd0) begin
            mul_acc_ff <= mul_acc_ff + mul_add;
         end
         mul_step_ff <= mul_step_ff + 3'd1;
      end
      if (mul_rnd_ff) begin
         mul_res_ff <= (mul_rnd_sum[128:64+VarShift] != '0) ? '1
                       : mul_rnd_sum[63+VarShift:VarShift];
      end
   end

   // ---------------- integer square root, two radicand bits per cycle ----------------
   logic [WordWidth-1:0] rt_x_ff, rt_res_ff, rt_bit_ff, rt_sum;
   logic [WordWidth-1:0] var_ff;
   logic                 rt_busy_ff, rt_done_ff, rt_start, rt_ge;

   assign rt_start = cmd.start && (cmd.op == OP_ROOT);
   assign rt_sum   = rt_res_ff + rt_bit_ff;
   assign rt_ge    = (rt_x_ff >= rt_sum);

   always_ff @(posedge clock) begin
      if (reset) begin
         rt_busy_ff <= 1'b0;
         rt_done_ff <= 1'b0;
      end else begin
         rt_done_ff <= rt_busy_ff && rt_bit_ff[0];
         if (rt_start) begin
            rt_busy_ff <= 1'b1;
         end else if (rt_busy_ff && rt_bit_ff[0]) begin
            rt_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rt_start) begin
         rt_x_ff   <= var_ff;
         rt_res_ff <= '0;
         rt_bit_ff <= 64'd1 << 62;
      end else if (rt_busy_ff) begin
         if (rt_ge) begin
            rt_x_ff   <= rt_x_ff - rt_sum;
            rt_res_ff <= (rt_res_ff >> 1) + rt_bit_ff;
         end else begin
            rt_res_ff <= rt_res_ff >> 1;
         end
         rt_bit_ff <= rt_bit_ff >> 2;
      end
   end

   // ---------------- shared divider ----------------
   logic [WordWidth-1:0] div_x, div_d, div_q;
   logic [ShWidth-1:0]   div_sh;
   logic                 div_start, div_done;
   logic [WordWidth-1:0] pi_ff, thw_ff, var1_ff, top, top_abs;
   logic                 top_neg;

   assign top     = pi_ff - thw_ff;
   assign top_neg = top[63];
   assign top_abs = top_neg ? (64'd0 - top) : top;

   assign div_start = cmd.start &&
                      (cmd.op == OP_PI || cmd.op == OP_THW || cmd.op == OP_QUOT);

   always_comb begin
      case (cmd.op)
         OP_PI: begin
            div_x  = 64'(diff_ff);
            div_sh = ShPi;
            div_d  = 64'(pidiv_ff);
         end
         OP_THW: begin
            div_x  = 64'(site_ff);
            div_sh = ShThw;
            div_d  = hs1_ff;
         end
         default: begin
            div_x  = top_abs;
            div_sh = ShQuot;
            div_d  = {32'b0, rt_res_ff[31:0]};
         end
      endcase
   end

   tds_divider u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .x     (div_x),
      .sh    (div_sh),
      .d     (div_d),
      .done  (div_done),
      .q     (div_q)
   );

   // ---------------- capture unit results ----------------
   logic [64:0]       var_sum;
   logic [56:0]       quot_rnd;
   logic [DWidth-1:0] d_ff, d_in, neg_mag;

   always_comb begin
      var_sum  = {1'b0, var1_ff} + {1'b0, mul_res_ff};
      quot_rnd = 57'(div_q[63:8]) + 57'(div_q[7]);
      neg_mag  = (quot_rnd > 57'h80000000) ? 32'h80000000 : quot_rnd[31:0];
      if (top_neg) begin
         d_in = 32'd0 - neg_mag;
      end else begin
         d_in = (quot_rnd > 57'h7FFFFFFF) ? 32'h7FFFFFFF : quot_rnd[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (mul_done_ff && cmd.op == OP_VAR1) var1_ff <= mul_res_ff;
      if (mul_done_ff && cmd.op == OP_VAR2) var_ff <= var_sum[64] ? '1 : var_sum[63:0];
      if (div_done && cmd.op == OP_PI) pi_ff <= div_q;
      if (div_done && cmd.op == OP_THW) thw_ff <= div_q;
      if (div_done && cmd.op == OP_QUOT) d_ff <= d_in;
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_d_stat          <= (var_ff == '0) ? '0 : d_ff;
         rsp_theta_pi        <= pi_ff[63:24] + 40'(pi_ff[23]);
         rsp_theta_watterson <= thw_ff[63:24] + 40'(thw_ff[23]);
         rsp_status          <= (var_ff == '0);
      end
   end

   assign stat.last      = last_ff;
   assign stat.mul_done  = mul_done_ff;
   assign stat.div_done  = div_done;
   assign stat.root_done = rt_done_ff;
   assign stat.var_zero  = (var_ff == '0);

endmodule

// ===== rtl/core/tajimas_d_statistic_unit.sv =====
`timescale 1ns / 1ps
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid/req_ready   | req_site_alleles, req_last_site
// rsp     | out       | rsp_valid/rsp_ready   | rsp_d_stat, rsp_theta_pi,
//         |           |                       | rsp_theta_watterson, rsp_status
// csr     | in        | csr_psel/penable      | csr_paddr, csr_pwdata, csr_prdata
//
// Each site item passes through four steps: capture, two popcount steps, accumulate.
// A last site then runs the closing math: two multiplies, two quotients on the
// bit-serial divider, the square root and a third quotient (the root and the
// third quotient are skipped when the variance is zero).
// Reset is synchronous; accumulators clear on reset and after each result.
// A finished result waits in its register while new sites are taken.

module tajimas_d_statistic_unit
   import tds_pkg::*;
#(
   parameter int unsigned MAX_SAMPLES = 64,
   parameter int unsigned MAX_SITES   = 65536
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [AlleleWidth-1:0]   req_site_alleles,
   input  logic                     req_last_site,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DWidth-1:0] rsp_d_stat,
   output logic [ThetaWidth-1:0]    rsp_theta_pi,
   output logic [ThetaWidth-1:0]    rsp_theta_watterson,
   output logic                     rsp_status,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [2:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   logic [SampleWidth-1:0] num_samples_ff;
   cmd_type                cmd;
   stat_type               stat;

   // Register file: one register, sample count
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == RegNumSamples) ? 32'(num_samples_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_samples_ff <= NumSamplesReset;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == RegNumSamples) begin
         num_samples_ff <= csr_pwdata[SampleWidth-1:0];
      end
   end

   tds_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tds_datapath #(
      .MAX_SAMPLES (MAX_SAMPLES),
      .MAX_SITES   (MAX_SITES)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .num_samples         (num_samples_ff),
      .req_site_alleles    (req_site_alleles),
      .req_last_site       (req_last_site),
      .rsp_d_stat          (rsp_d_stat),
      .rsp_theta_pi        (rsp_theta_pi),
      .rsp_theta_watterson (rsp_theta_watterson),
      .rsp_status          (rsp_status)
   );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
   import tds_pkg::*;

   localparam int unsigned LIMIT_CYCLES = 4000000;
   localparam int unsigned SETTLE_CYCLES = 450;
   localparam logic [2:0] ADDR_NUM_SAMPLES = {RegNumSamples, 2'b00};

   typedef struct packed {
      logic signed [DWidth-1:0] d;
      logic [ThetaWidth-1:0] pi;
      logic [ThetaWidth-1:0] thw;
      logic status;
   } tds_result_type;

   typedef struct {
      int n;
      logic [AlleleWidth-1:0] alleles;
      bit last;
      bit typed;
      tds_result_type want;
   } site_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [AlleleWidth-1:0] req_site_alleles = '0;
   logic req_last_site = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [DWidth-1:0] rsp_d_stat;
   logic [ThetaWidth-1:0] rsp_theta_pi;
   logic [ThetaWidth-1:0] rsp_theta_watterson;
   logic rsp_status;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [2:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   // Shadow of the block's state
   logic [6:0] shadow_samples;
   logic [63:0] shadow_diffs;
   logic [63:0] shadow_sites;
   tds_result_type result_q[$];
   bit typed_q[$];
   tds_result_type typed_want_q[$];

   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned results_seen = 0;
   int unsigned sites_sent = 0;
   int unsigned rsp_wait = 0;
   bit idle_on = 1'b0;

   tajimas_d_statistic_unit i_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // round(x * 2^sh / d), ties up, saturating at all ones
   function automatic logic [63:0] div_round(logic [63:0] x, int sh, logic [63:0] d);
      logic [159:0] num;
      logic [159:0] quot;
      logic [159:0] rem;
      if (d == '0 || d[63:62] != 2'b00) return '1;
      num = {96'b0, x} << sh;
      quot = num / {96'b0, d};
      rem = num % {96'b0, d};
      if (rem >= {96'b0, d} - rem) quot = quot + 1;
      if (quot[159:64] != '0) return '1;
      return quot[63:0];
   endfunction

   // round(a * b / 2^sh), ties up, saturating
   function automatic logic [63:0] mul_round(logic [63:0] a, logic [63:0] b, int sh);
      logic [129:0] prod;
      prod = {66'b0, a} * {66'b0, b} + (130'd1 << (sh - 1));
      if ((prod >> (64 + sh)) != '0) return '1;
      return 64'(prod >> sh);
   endfunction

   function automatic logic [63:0] root_floor(logic [63:0] x);
      logic [63:0] acc;
      logic [63:0] bitv;
      acc = '0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != '0) begin
         if (x >= acc + bitv) begin
            x = x - (acc + bitv);
            acc = (acc >> 1) + bitv;
         end else begin
            acc = acc >> 1;
         end
         bitv = bitv >> 2;
      end
      return acc;
   endfunction

   function automatic logic [39:0] q40_to_q16(logic [63:0] v);
      return 40'((v >> 24) + ((v >> 23) & 64'd1));
   endfunction

   // Accumulate one site; on the last site work out the statistic
   function automatic bit tajima_step(logic [63:0] alleles, logic last,
                                      output tds_result_type res);
      logic [63:0] n, k, hs1, hs2, bb1, bb2, inv, tt, sq, cc1, cc2, ee1, ee2, den;
      logic [63:0] var_q32, mag, sd, pi, thw, s, top, amag;
      int i;
      n = 64'(shadow_samples);
      if (n < 2) n = 2;
      if (n > 64) n = 64;
      if (n < 64) alleles = alleles & ((64'd1 << n) - 1);
      k = '0;
      for (i = 0; i < 64; i++) k = k + alleles[i];
      shadow_diffs = shadow_diffs + k * (n - k);
      if (shadow_diffs > 64'd134217727) shadow_diffs = 64'd134217727;
      if (shadow_sites < 64'd65536) shadow_sites = shadow_sites + 1;
      res = '0;
      if (!last) return 1'b0;
      s = shadow_sites;
      hs1 = '0;
      hs2 = '0;
      for (i = 1; i < n; i++) begin
         hs1 = hs1 + div_round(64'd1, 40, 64'(i));
         hs2 = hs2 + div_round(64'd1, 40, 64'(i * i));
      end
      bb1 = div_round(n + 1, 40, 3 * (n - 1));
      bb2 = div_round(2 * (n * n + n + 3), 40, 9 * n * (n - 1));
      inv = div_round(64'd1, 80, hs1);
      tt = div_round((n + 2) * inv, 0, n);
      sq = mul_round(hs2, mul_round(inv, inv, 40), 40);
      cc1 = bb1 - inv;
      cc2 = bb2 - tt + sq;
      // drop rounding residue, negative included
      if ($signed(cc1) < 64'sd256) cc1 = '0;
      if ($signed(cc2) < 64'sd256) cc2 = '0;
      ee1 = mul_round(cc1, inv, 40);
      den = mul_round(hs1, hs1, 40) + hs2;
      ee2 = div_round(cc2, 40, den);
      var_q32 = mul_round(ee1, s, 8);
      mag = mul_round(ee2, s * (s - 1), 8);
      var_q32 = (var_q32 > ~mag) ? '1 : var_q32 + mag;
      pi = div_round(shadow_diffs, 40, n * (n - 1) / 2);
      thw = div_round(s, 80, hs1);
      res.pi = q40_to_q16(pi);
      res.thw = q40_to_q16(thw);
      if (var_q32 == '0) begin
         res.status = 1'b1;
      end else begin
         sd = root_floor(var_q32);
         top = pi - thw;
         amag = top[63] ? -top : top;
         mag = div_round(amag, 0, sd);
         mag = (mag >> 8) + ((mag >> 7) & 64'd1);
         if (top[63]) begin
            if (mag > 64'h80000000) mag = 64'h80000000;
            res.d = 32'(-mag);
         end else begin
            res.d = (mag > 64'h7FFFFFFF) ? 32'h7FFFFFFF : 32'(mag);
         end
      end
      shadow_diffs = '0;
      shadow_sites = '0;
      return 1'b1;
   endfunction

   // Predict on every accepted site item
   always @(posedge clock) begin
      tds_result_type res;
      cycle_count <= cycle_count + 1;
      if (!reset && req_valid && req_ready) begin
         if (tajima_step(req_site_alleles, req_last_site, res)) result_q.push_back(res);
      end
      if (cycle_count > LIMIT_CYCLES) begin
         $display("%0t: timeout with %0d results pending", $time, result_q.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Check each accepted result against the oldest prediction
   always @(posedge clock) begin
      tds_result_type want;
      tds_result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_d_stat, rsp_theta_pi, rsp_theta_watterson, rsp_status};
         rsp_wait = idle_on ? $urandom_range(0, 14) : 0;
         results_seen++;
         if (result_q.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result d=%h", $time, got.d);
         end else begin
            want = result_q.pop_front();
            if (typed_q.size() != 0 && typed_q.pop_front()) want = typed_want_q.pop_front();
            if (got.d !== want.d) begin
               error_count++;
               $display("%0t: d_stat exp %h got %h", $time, want.d, got.d);
            end
            if (got.pi !== want.pi) begin
               error_count++;
               $display("%0t: theta_pi exp %h got %h", $time, want.pi, got.pi);
            end
            if (got.thw !== want.thw) begin
               error_count++;
               $display("%0t: theta_w exp %h got %h", $time, want.thw, got.thw);
            end
            if (got.status !== want.status) begin
               error_count++;
               $display("%0t: status exp %b got %b", $time, want.status, got.status);
            end
         end
      end
   end

   // Stall the result side
   always @(negedge clock) begin
      if (rsp_wait > 0) begin
         rsp_ready <= 1'b0;
         rsp_wait = rsp_wait - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_site(logic [63:0] alleles, logic last, int gap);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_site_alleles <= alleles;
      req_last_site <= last;
      do @(posedge clock); while (!req_ready);
      sites_sent++;
   endtask

   task automatic hold_req;
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // Write the sample count once the block has gone quiet
   task automatic write_samples(logic [6:0] value);
      hold_req();
      while (result_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_NUM_SAMPLES;
      csr_pwdata <= {25'($urandom_range(0, 32'h1FFFFFF)), value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      shadow_samples = value;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   function automatic logic [63:0] random_alleles();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return '1;
         2: return 64'd1 << $urandom_range(0, 63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   site_row_type rows[$];

   initial begin
      int cur_n;
      int len;
      int nsets;
      int j;
      shadow_samples = NumSamplesReset;
      shadow_diffs = '0;
      shadow_sites = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed rows: counts below two act as two, so the thetas read off directly
      rows = '{
         '{64, 64'h0, 1, 0, '0},
         '{64, '1, 1, 0, '0},
         '{64, 64'hAAAAAAAAAAAAAAAA, 0, 0, '0},
         '{64, 64'h5555555555555555, 1, 0, '0},
         '{0, '1, 1, 1, '{32'sd0, 40'd0, 40'd65536, 1'b1}},
         '{0, 64'h1, 0, 0, '0},
         '{0, 64'h2, 1, 1, '{32'sd0, 40'd131072, 40'd131072, 1'b1}},
         '{1, 64'h3, 1, 1, '{32'sd0, 40'd0, 40'd65536, 1'b1}},
         '{3, 64'h7, 0, 0, '0},
         '{3, 64'h1, 1, 0, '0},
         '{127, 64'h8000000000000001, 1, 0, '0},
         '{65, 64'hFFFFFFFF00000000, 0, 0, '0},
         '{65, 64'h00000000FFFFFFFF, 1, 0, '0},
         '{4, 64'hFFFFFFFFFFFFFFF0, 1, 0, '0},
         '{63, 64'h8000000000000000, 0, 0, '0},
         '{63, 64'h4000000000000001, 1, 0, '0},
         '{2, 64'h1, 1, 1, '{32'sd0, 40'd65536, 40'd65536, 1'b1}}
      };
      cur_n = 64;
      foreach (rows[r]) begin
         if (rows[r].n != cur_n) begin
            write_samples(7'(rows[r].n));
            cur_n = rows[r].n;
         end
         if (rows[r].last) begin
            typed_q.push_back(rows[r].typed);
            typed_want_q.push_back(rows[r].want);
            if (!rows[r].typed) typed_want_q.pop_back();
         end
         send_site(rows[r].alleles, rows[r].last, 0);
      end

      // Random site sets, sample count changed every eight sets
      nsets = 0;
      while (sites_sent < 640) begin
         if (nsets % 8 == 0) begin
            case ($urandom_range(0, 3))
               0: write_samples(7'd2);
               1: write_samples(7'd64);
               default: write_samples(7'($urandom_range(0, 127)));
            endcase
            idle_on = $urandom_range(0, 3) != 0;
         end
         len = $urandom_range(1, 12);
         for (j = 0; j < len; j++) begin
            send_site(random_alleles(), j == len - 1, idle_on ? $urandom_range(0, 14) : 0);
         end
         nsets++;
      end
      hold_req();

      while (result_q.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Sent %0d site items: the directed table, then %0d random sets;", sites_sent,
               nsets);
      $display("checked %0d results across sample counts 2 to 64.", results_seen);
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== tajimas_d_statistic_unit.f =====
rtl/core/tds_pkg.sv
rtl/core/tds_divider.sv
rtl/core/tds_ctrl.sv
rtl/core/tds_datapath.sv
rtl/core/tajimas_d_statistic_unit.sv
verif/testbench.sv
